### design/cotangent_edge_weight_core_macros.svh
// assertion helpers for the cotangent edge weight core
`ifndef COTANGENT_EDGE_WEIGHT_CORE_MACROS_SVH
`define COTANGENT_EDGE_WEIGHT_CORE_MACROS_SVH

`ifndef SYNTH
`define CEW_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cotangent edge weight core: check failed");
`define CEW_ASSERT_ALWAYS(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) \
    else $error("cotangent edge weight core: check failed");
`else
`define CEW_ASSERT_IMPL(label, clk_s, rst_s, ante, cons)
`define CEW_ASSERT_ALWAYS(label, clk_s, rst_s, cond)
`endif

`endif

### design/cewt_pkg.sv
`timescale 1ns / 1ps
package cewt_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;
  localparam int PROD_W     = 66;
  localparam int DOT_W      = 67;
  localparam int CROSS_W    = 67;
  localparam int MAGN_W     = 66;
  localparam int HALF_W     = 33;
  localparam int SQ_W       = 132;
  localparam int FALLBACK_W = 31;
  localparam int WEIGHT_W   = 32;

  localparam logic [FALLBACK_W-1:0] FALLBACK_RESET = 31'd65536000;
  localparam logic [WEIGHT_W-1:0]   WEIGHT_MAX     = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0]   WEIGHT_MIN     = 32'h8000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t src_x;
    coord_t src_y;
    coord_t src_z;
    coord_t dst_x;
    coord_t dst_y;
    coord_t dst_z;
    coord_t apex1_x;
    coord_t apex1_y;
    coord_t apex1_z;
    coord_t apex2_x;
    coord_t apex2_y;
    coord_t apex2_z;
  } item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic                       degenerate;
    logic                       saturated;
  } result_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } lane_ctl_t;

endpackage

### design/cewt_geom.sv
`timescale 1ns / 1ps
module cewt_geom #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       valid_in,
  input  cewt_pkg::point_t                           pu,
  input  cewt_pkg::point_t                           pv,
  input  cewt_pkg::point_t                           apex,
  output cewt_pkg::lane_ctl_t                        ctl,
  output logic [cewt_pkg::SQ_W+2*FRAC_BITS-1:0]      t,
  output logic [cewt_pkg::SQ_W-1:0]                  c2
);

  localparam int T_W = cewt_pkg::SQ_W + 2 * FRAC_BITS;
  localparam int HW  = cewt_pkg::HALF_W;

  logic v1, v2, v3, v4, v5, v6;
  logic n4, n5, n6;
  logic signed [cewt_pkg::DIFF_W-1:0]  du [3];
  logic signed [cewt_pkg::DIFF_W-1:0]  dv [3];
  logic signed [cewt_pkg::PROD_W-1:0]  pr [9];
  logic signed [cewt_pkg::DOT_W-1:0]   dot;
  logic signed [cewt_pkg::CROSS_W-1:0] cr [3];
  logic [cewt_pkg::MAGN_W-1:0]         mg [4];
  logic [2*HW-1:0]                     hh [4];
  logic [2*HW-1:0]                     hl [4];
  logic [2*HW-1:0]                     ll [4];
  logic [cewt_pkg::SQ_W-1:0]           sq [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      ctl.valid <= 1'b0;
    end else begin
      v1 <= valid_in;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      ctl.valid <= v6;
    end
    ctl.neg <= n6;
  end

  always_ff @(posedge clk) begin
    // edge vectors from the apex
    du[0] <= cewt_pkg::DIFF_W'(pu.x) - cewt_pkg::DIFF_W'(apex.x);
    du[1] <= cewt_pkg::DIFF_W'(pu.y) - cewt_pkg::DIFF_W'(apex.y);
    du[2] <= cewt_pkg::DIFF_W'(pu.z) - cewt_pkg::DIFF_W'(apex.z);
    dv[0] <= cewt_pkg::DIFF_W'(pv.x) - cewt_pkg::DIFF_W'(apex.x);
    dv[1] <= cewt_pkg::DIFF_W'(pv.y) - cewt_pkg::DIFF_W'(apex.y);
    dv[2] <= cewt_pkg::DIFF_W'(pv.z) - cewt_pkg::DIFF_W'(apex.z);

    // dot terms, then cross terms
    pr[0] <= du[0] * dv[0];
    pr[1] <= du[1] * dv[1];
    pr[2] <= du[2] * dv[2];
    pr[3] <= du[1] * dv[2];
    pr[4] <= du[2] * dv[1];
    pr[5] <= du[2] * dv[0];
    pr[6] <= du[0] * dv[2];
    pr[7] <= du[0] * dv[1];
    pr[8] <= du[1] * dv[0];

    dot   <= cewt_pkg::DOT_W'(pr[0]) + cewt_pkg::DOT_W'(pr[1]) + cewt_pkg::DOT_W'(pr[2]);
    cr[0] <= cewt_pkg::CROSS_W'(pr[3]) - cewt_pkg::CROSS_W'(pr[4]);
    cr[1] <= cewt_pkg::CROSS_W'(pr[5]) - cewt_pkg::CROSS_W'(pr[6]);
    cr[2] <= cewt_pkg::CROSS_W'(pr[7]) - cewt_pkg::CROSS_W'(pr[8]);

    // magnitudes
    n4    <= dot[cewt_pkg::DOT_W-1];
    mg[0] <= dot[cewt_pkg::DOT_W-1] ? cewt_pkg::MAGN_W'(-dot) : cewt_pkg::MAGN_W'(dot);
    for (int i = 0; i < 3; i++) begin
      mg[i+1] <= cr[i][cewt_pkg::CROSS_W-1] ? cewt_pkg::MAGN_W'(-cr[i])
                                             : cewt_pkg::MAGN_W'(cr[i]);
    end

    // squares as half-word partial products
    n5 <= n4;
    for (int i = 0; i < 4; i++) begin
      hh[i] <= mg[i][2*HW-1:HW] * mg[i][2*HW-1:HW];
      hl[i] <= mg[i][2*HW-1:HW] * mg[i][HW-1:0];
      ll[i] <= mg[i][HW-1:0] * mg[i][HW-1:0];
    end

    n6 <= n5;
    for (int i = 0; i < 4; i++) begin
      sq[i] <= (cewt_pkg::SQ_W'(hh[i]) << (2 * HW)) + (cewt_pkg::SQ_W'(hl[i]) << (HW + 1))
               + cewt_pkg::SQ_W'(ll[i]);
    end

    t       <= T_W'(sq[0]) << (2 * FRAC_BITS);
    c2      <= sq[1] + sq[2] + sq[3];
  end

endmodule

### design/cewt_root_stage.sv
`timescale 1ns / 1ps
module cewt_root_stage #(
  parameter int FRAC_BITS = 16,
  parameter int K         = 0
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  cewt_pkg::lane_ctl_t                             ctl_in,
  input  logic [cewt_pkg::SQ_W+2*FRAC_BITS-1:0]           rem_in,
  input  logic [cewt_pkg::SQ_W+FRAC_BITS-1:0]             acc_in,
  input  logic [cewt_pkg::MAGN_W+FRAC_BITS-1:0]           mag_in,
  input  logic [cewt_pkg::SQ_W-1:0]                       c2_in,
  output cewt_pkg::lane_ctl_t                             ctl_out,
  output logic [cewt_pkg::SQ_W+2*FRAC_BITS-1:0]           rem_out,
  output logic [cewt_pkg::SQ_W+FRAC_BITS-1:0]             acc_out,
  output logic [cewt_pkg::MAGN_W+FRAC_BITS-1:0]           mag_out,
  output logic [cewt_pkg::SQ_W-1:0]                       c2_out
);

  localparam int T_W   = cewt_pkg::SQ_W + 2 * FRAC_BITS;
  localparam int P_W   = cewt_pkg::SQ_W + FRAC_BITS;
  localparam int MAG_W = cewt_pkg::MAGN_W + FRAC_BITS;
  localparam int D_W   = cewt_pkg::SQ_W + 2 * MAG_W;

  logic [D_W-1:0] d;
  logic           take;

  // (m + 2^K)^2 c2 - m^2 c2 = (m c2) 2^(K+1) + c2 2^(2K)
  assign d    = (D_W'(acc_in) << (K + 1)) + (D_W'(c2_in) << (2 * K));
  assign take = D_W'(rem_in) >= d;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.neg <= ctl_in.neg;
  end

  always_ff @(posedge clk) begin
    c2_out      <= c2_in;
    rem_out     <= take ? rem_in - T_W'(d) : rem_in;
    acc_out     <= take ? acc_in + (P_W'(c2_in) << K) : acc_in;
    mag_out     <= take ? mag_in | (MAG_W'(1) << K) : mag_in;
  end

endmodule

### design/cewt_root.sv
`timescale 1ns / 1ps
module cewt_root #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  cewt_pkg::lane_ctl_t                        ctl_in,
  input  logic [cewt_pkg::SQ_W+2*FRAC_BITS-1:0]      t,
  input  logic [cewt_pkg::SQ_W-1:0]                  c2,
  output cewt_pkg::lane_ctl_t                        ctl_out,
  output logic [cewt_pkg::MAGN_W+FRAC_BITS-1:0]      mag,
  output logic                                       deg
);

  localparam int T_W   = cewt_pkg::SQ_W + 2 * FRAC_BITS;
  localparam int P_W   = cewt_pkg::SQ_W + FRAC_BITS;
  localparam int MAG_W = cewt_pkg::MAGN_W + FRAC_BITS;

  cewt_pkg::lane_ctl_t       ctl_w [MAG_W+1];
  logic [T_W-1:0]            rem_w [MAG_W+1];
  logic [P_W-1:0]            acc_w [MAG_W+1];
  logic [MAG_W-1:0]          mag_w [MAG_W+1];
  logic [cewt_pkg::SQ_W-1:0] c2_w  [MAG_W+1];

  assign ctl_w[0] = ctl_in;
  assign rem_w[0] = t;
  assign acc_w[0] = '0;
  assign mag_w[0] = '0;
  assign c2_w[0]  = c2;

  // one result bit per stage, most significant first
  for (genvar i = 0; i < MAG_W; i++) begin : g_stage
    cewt_root_stage #(
      .FRAC_BITS(FRAC_BITS),
      .K        (MAG_W - 1 - i)
    ) u_stage (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_w[i]),
      .rem_in (rem_w[i]),
      .acc_in (acc_w[i]),
      .mag_in (mag_w[i]),
      .c2_in  (c2_w[i]),
      .ctl_out(ctl_w[i+1]),
      .rem_out(rem_w[i+1]),
      .acc_out(acc_w[i+1]),
      .mag_out(mag_w[i+1]),
      .c2_out (c2_w[i+1])
    );
  end

  assign ctl_out.valid = ctl_w[MAG_W].valid;
  // a zero cotangent carries no sign
  assign ctl_out.neg   = ctl_w[MAG_W].neg && (mag_w[MAG_W] != '0);
  assign mag           = mag_w[MAG_W];
  assign deg           = c2_w[MAG_W] == '0;

endmodule

### design/cotangent_edge_weight_core.sv
`timescale 1ns / 1ps
// Cotangent edge weight core. Pulse start with one edge word on item (endpoints src and dst,
// apexes apex1 and apex2, signed fixed point with COORD_FRAC_BITS fraction bits); a new word
// can be given every clock cycle, and busy is high only during reset. Each word gives exactly
// one result word, shown on result for one cycle with done high; the receiver cannot stall,
// so results must be taken as they appear. A word passes through seven stages of vector,
// dot, cross and square arithmetic, then the bit-per-stage cotangent root search, one stage
// for each of the COORD_FRAC_BITS + 66 bits of the cotangent magnitude, and then two stages
// that combine and saturate. The weight is half the sum of the two cotangents, truncated
// toward zero; when either cross product is zero the word is flagged degenerate and carries
// the fallback weight, and a weight outside the 32-bit range is clipped and flagged
// saturated. The fallback weight (1000.0 after reset) is written with cfg_we and should
// change only while no word is in flight.
`include "cotangent_edge_weight_core_macros.svh"
module cotangent_edge_weight_core #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  cewt_pkg::item_t                     item,
  output logic                                done,
  output cewt_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [cewt_pkg::FALLBACK_W-1:0]     cfg_wdata
);

  localparam int T_W   = cewt_pkg::SQ_W + 2 * COORD_FRAC_BITS;
  localparam int MAG_W = cewt_pkg::MAGN_W + COORD_FRAC_BITS;
  // registers from start to done: geometry, root search, combine, output
  localparam int LAT   = 7 + MAG_W + 2;

  cewt_pkg::point_t pa, pb, pc, pd;

  // geometry lane outputs
  cewt_pkg::lane_ctl_t g1_ctl, g2_ctl;
  logic [T_W-1:0]            g1_t, g2_t;
  logic [cewt_pkg::SQ_W-1:0] g1_c2, g2_c2;

  // root search outputs
  cewt_pkg::lane_ctl_t r1_ctl, r2_ctl;
  logic [MAG_W-1:0]    r1_mag, r2_mag;
  logic                r1_deg, r2_deg;

  // combine stage
  logic             s_valid, s_neg, s_deg;
  logic [MAG_W:0]   s_sum;
  logic [MAG_W:0]   sum_next;
  logic             neg_next;
  logic [MAG_W-1:0] half;
  logic             sat_pos, sat_neg;

  logic [cewt_pkg::FALLBACK_W-1:0] fallback_weight;

  // no backpressure: words are taken every cycle outside reset
  assign busy = rst;

  assign pa = '{x: item.src_x,   y: item.src_y,   z: item.src_z};
  assign pb = '{x: item.dst_x,   y: item.dst_y,   z: item.dst_z};
  assign pc = '{x: item.apex1_x, y: item.apex1_y, z: item.apex1_z};
  assign pd = '{x: item.apex2_x, y: item.apex2_y, z: item.apex2_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_weight <= cewt_pkg::FALLBACK_RESET;
    end else if (cfg_we) begin
      fallback_weight <= cfg_wdata;
    end
  end

  // angle at apex1 between (dst - apex1) and (src - apex1)
  cewt_geom #(.FRAC_BITS(COORD_FRAC_BITS)) u_geom1 (
    .clk     (clk),
    .rst     (rst),
    .valid_in(start && !busy),
    .pu      (pb),
    .pv      (pa),
    .apex    (pc),
    .ctl     (g1_ctl),
    .t       (g1_t),
    .c2      (g1_c2)
  );

  // angle at apex2 between (src - apex2) and (dst - apex2)
  cewt_geom #(.FRAC_BITS(COORD_FRAC_BITS)) u_geom2 (
    .clk     (clk),
    .rst     (rst),
    .valid_in(start && !busy),
    .pu      (pa),
    .pv      (pb),
    .apex    (pd),
    .ctl     (g2_ctl),
    .t       (g2_t),
    .c2      (g2_c2)
  );

  // largest m with m^2 * |cross|^2 <= dot^2 * 2^(2F)
  cewt_root #(.FRAC_BITS(COORD_FRAC_BITS)) u_root1 (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (g1_ctl),
    .t      (g1_t),
    .c2     (g1_c2),
    .ctl_out(r1_ctl),
    .mag    (r1_mag),
    .deg    (r1_deg)
  );

  cewt_root #(.FRAC_BITS(COORD_FRAC_BITS)) u_root2 (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (g2_ctl),
    .t      (g2_t),
    .c2     (g2_c2),
    .ctl_out(r2_ctl),
    .mag    (r2_mag),
    .deg    (r2_deg)
  );

  // signed sum of the two cotangents in sign-magnitude form
  always_comb begin
    priority if (r1_ctl.neg == r2_ctl.neg) begin
      sum_next = (MAG_W + 1)'(r1_mag) + (MAG_W + 1)'(r2_mag);
      neg_next = r1_ctl.neg;
    end else if (r1_mag >= r2_mag) begin
      sum_next = (MAG_W + 1)'(r1_mag - r2_mag);
      neg_next = r1_ctl.neg;
    end else begin
      sum_next = (MAG_W + 1)'(r2_mag - r1_mag);
      neg_next = r2_ctl.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= r1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s_sum <= sum_next;
    s_neg <= neg_next;
    s_deg <= r1_deg || r2_deg;
  end

  // halve toward zero, then clip to the 32-bit range
  assign half    = s_sum[MAG_W:1];
  assign sat_pos = !s_neg && (half > MAG_W'(cewt_pkg::WEIGHT_MAX));
  assign sat_neg = s_neg && (half > MAG_W'(cewt_pkg::WEIGHT_MIN));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    priority if (s_deg) begin
      result.edge_weight <= cewt_pkg::WEIGHT_W'(fallback_weight);
      result.degenerate  <= 1'b1;
      result.saturated   <= 1'b0;
    end else if (sat_pos || sat_neg) begin
      result.edge_weight <= sat_neg ? cewt_pkg::WEIGHT_MIN : cewt_pkg::WEIGHT_MAX;
      result.degenerate  <= 1'b0;
      result.saturated   <= 1'b1;
    end else begin
      result.edge_weight <= s_neg ? -half[cewt_pkg::WEIGHT_W-1:0]
                                  : half[cewt_pkg::WEIGHT_W-1:0];
      result.degenerate  <= 1'b0;
      result.saturated   <= 1'b0;
    end
  end

  // both lanes walk the same pipeline
  `CEW_ASSERT_ALWAYS(a_lane_sync, clk, rst, r1_ctl.valid == r2_ctl.valid && g1_ctl.valid == g2_ctl.valid)
  // every done traces back to a start a fixed latency earlier
  `CEW_ASSERT_IMPL(a_latency, clk, rst, done, $past(start && !busy, LAT))
  `CEW_ASSERT_IMPL(a_flags, clk, rst, done, !(result.degenerate && result.saturated))
  `CEW_ASSERT_IMPL(a_fallback, clk, rst, done && result.degenerate, result.edge_weight == cewt_pkg::WEIGHT_W'(fallback_weight))

endmodule
